/* src/video_dot_timing_scroll_address_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dot timing scroll address block
// Shared property templates, clocked on aclk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_DOT_TIMING_SCROLL_ADDRESS_DEFINES_SVH
`define VIDEO_DOT_TIMING_SCROLL_ADDRESS_DEFINES_SVH

// Same-cycle implication.
`define VDTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VDTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/vdts_pkg.sv */
// ----------------------------------------------------------------------------
// vdts_pkg
// Shared widths, timing constants and decode types for the scroll counter.
// ----------------------------------------------------------------------------
package vdts_pkg;

    localparam int CNT_W  = 9;
    localparam int ADDR_W = 15;
    localparam int VADR_W = 14;

    localparam logic [CNT_W-1:0] DOT_LAST        = 9'd340;
    localparam logic [CNT_W-1:0] LINE_LAST       = 9'd261;
    localparam logic [CNT_W-1:0] LINE_VIS_LAST   = 9'd239;
    localparam logic [CNT_W-1:0] LINE_VBLANK     = 9'd241;
    localparam logic [CNT_W-1:0] DOT_VBLANK      = 9'd1;
    localparam logic [CNT_W-1:0] DOT_Y_STEP      = 9'd256;
    localparam logic [CNT_W-1:0] DOT_H_COPY      = 9'd257;
    localparam logic [CNT_W-1:0] DOT_PREFETCH    = 9'd337;
    localparam logic [CNT_W-1:0] DOT_V_COPY_LO   = 9'd280;
    localparam logic [CNT_W-1:0] DOT_V_COPY_HI   = 9'd304;

    localparam logic [ADDR_W-1:0] MASK_HORIZ = 15'h041F;
    localparam logic [ADDR_W-1:0] MASK_VERT  = 15'h7BE0;

    localparam logic [4:0] ROW_TOGGLE = 5'd29;
    localparam logic [4:0] ROW_WRAP   = 5'd31;

    localparam logic [VADR_W-1:0] ATTR_BASE = 14'h23C0;

    // Address update requests decoded from the dot position.
    typedef struct packed {
        logic x_step;
        logic y_step;
        logic h_copy;
        logic v_copy;
    } addr_ops_t;

endpackage

/* src/vdts_timing.sv */
// ----------------------------------------------------------------------------
// vdts_timing
// Dot/line counter advance, vblank flag and address-op decode.
// ----------------------------------------------------------------------------
module vdts_timing (
    input  logic [vdts_pkg::CNT_W-1:0] dot,
    input  logic [vdts_pkg::CNT_W-1:0] line,
    input  logic                       vblank,
    input  logic                       render,
    output logic [vdts_pkg::CNT_W-1:0] dot_next,
    output logic [vdts_pkg::CNT_W-1:0] line_next,
    output logic                       vbl_next,
    output logic                       nmi,
    output logic                       frame_end,
    output vdts_pkg::addr_ops_t        ops
);
    import vdts_pkg::*;

    logic visible;
    logic prerender;
    logic fetch_dot;

    assign visible   = (line <= LINE_VIS_LAST);
    assign prerender = (line == LINE_LAST);
    // coarse X ticks every 8th dot from 8 to 248; no dot of 337..340 is a multiple of 8
    assign fetch_dot = (dot != '0) && (dot[2:0] == 3'd0)
                     && ((dot < DOT_Y_STEP) || (dot >= DOT_PREFETCH));

    always_comb begin
        ops.x_step = render && visible && fetch_dot;
        ops.y_step = render && visible && (dot == DOT_Y_STEP);
        ops.h_copy = render && visible && (dot == DOT_H_COPY);
        ops.v_copy = render && prerender
                   && (dot >= DOT_V_COPY_LO) && (dot <= DOT_V_COPY_HI);
    end

    always_comb begin
        nmi      = 1'b0;
        vbl_next = vblank;
        if ((line == LINE_VBLANK) && (dot == DOT_VBLANK) && !vblank) begin
            vbl_next = 1'b1;
            nmi      = 1'b1;
        end else if (prerender && (dot == DOT_VBLANK)) begin
            vbl_next = 1'b0;
        end
    end

    always_comb begin
        frame_end = 1'b0;
        dot_next  = dot + 9'd1;
        line_next = line;
        if (dot >= DOT_LAST) begin
            dot_next = '0;
            if (line >= LINE_LAST) begin
                line_next = '0;
                frame_end = 1'b1;
            end else begin
                line_next = line + 9'd1;
            end
        end
    end

endmodule

/* src/vdts_scroll.sv */
// ----------------------------------------------------------------------------
// vdts_scroll
// Scroll address stepping and reload from the temporary address.
// ----------------------------------------------------------------------------
module vdts_scroll (
    input  logic [vdts_pkg::ADDR_W-1:0] addr,
    input  logic [vdts_pkg::ADDR_W-1:0] temp,
    input  vdts_pkg::addr_ops_t         ops,
    output logic [vdts_pkg::ADDR_W-1:0] addr_next
);
    import vdts_pkg::*;

    logic [ADDR_W-1:0] x_addr;
    logic [ADDR_W-1:0] y_addr;

    // coarse X: wrap at 31 and flip horizontal nametable
    always_comb begin
        x_addr = addr;
        if (addr[4:0] == 5'h1F) begin
            x_addr[4:0] = '0;
            x_addr[10]  = ~addr[10];
        end else begin
            x_addr[4:0] = addr[4:0] + 5'd1;
        end
    end

    // fine Y carries into coarse Y; row 29 flips vertical nametable
    always_comb begin
        y_addr = addr;
        if (addr[14:12] != 3'h7) begin
            y_addr[14:12] = addr[14:12] + 3'd1;
        end else begin
            y_addr[14:12] = '0;
            if (addr[9:5] == ROW_TOGGLE) begin
                y_addr[9:5] = '0;
                y_addr[11]  = ~addr[11];
            end else if (addr[9:5] == ROW_WRAP) begin
                y_addr[9:5] = '0;
            end else begin
                y_addr[9:5] = addr[9:5] + 5'd1;
            end
        end
    end

    always_comb begin
        addr_next = addr;
        if (ops.x_step) begin
            addr_next = x_addr;
        end else if (ops.y_step) begin
            addr_next = y_addr;
        end else if (ops.h_copy) begin
            addr_next = (addr & ~MASK_HORIZ) | (temp & MASK_HORIZ);
        end else if (ops.v_copy) begin
            addr_next = (addr & ~MASK_VERT) | (temp & MASK_VERT);
        end
    end

endmodule

/* src/video_dot_timing_scroll_address.sv */
// ----------------------------------------------------------------------------
// video_dot_timing_scroll_address
// Dot-rate raster timing and tile scroll address counter.
// ----------------------------------------------------------------------------
// One input beat is one video dot and yields exactly one output beat. A beat
// lands in an input register; when it advances, the dot/line counters, the
// vblank flag and the scroll address update while the result is loaded into
// the output register that drives m_tvalid. Throughput is one dot per clock
// while m_tready stays high. The rate is set by the update of the counter
// and address state, which every dot reads back. While a result waits for
// m_tready the empty input register still takes one beat, then s_tready
// drops; a stalled consumer costs no bubble once it resumes. With
// render_enable low the address holds, but counters and vblank keep running.
// m_tlast marks the last dot of a frame (line 261, dot 340).
// ----------------------------------------------------------------------------
module video_dot_timing_scroll_address (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] render_enable, [15:1] scroll_temp
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] dot_index, [17:9] line_index, [32:18] vram_address,
    // [46:33] tile_address, [60:47] attribute_address, [61] in_vblank,
    // [62] nmi_pulse, [63] zero
    output logic [63:0] m_tdata,
    output logic        m_tlast
);
    import vdts_pkg::*;

    // input stage
    logic              in_valid_reg;
    logic              render_reg;
    logic [ADDR_W-1:0] temp_reg;

    // raster and scroll state
    logic [CNT_W-1:0]  dot_reg;
    logic [CNT_W-1:0]  line_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic              vblank_reg;

    // output stage
    logic              out_valid_reg;
    logic [CNT_W-1:0]  out_dot_reg;
    logic [CNT_W-1:0]  out_line_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_vblank_reg;
    logic              out_nmi_reg;
    logic              out_last_reg;

    logic              advance;
    logic [CNT_W-1:0]  dot_next;
    logic [CNT_W-1:0]  line_next;
    logic [ADDR_W-1:0] addr_next;
    logic              vbl_next;
    logic              nmi;
    logic              frame_end;
    addr_ops_t         ops;

    logic [VADR_W-1:0] nt_addr;
    logic [VADR_W-1:0] at_addr;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    vdts_timing u_timing (
        .dot       (dot_reg),
        .line      (line_reg),
        .vblank    (vblank_reg),
        .render    (render_reg),
        .dot_next  (dot_next),
        .line_next (line_next),
        .vbl_next  (vbl_next),
        .nmi       (nmi),
        .frame_end (frame_end),
        .ops       (ops)
    );

    vdts_scroll u_scroll (
        .addr      (addr_reg),
        .temp      (temp_reg),
        .ops       (ops),
        .addr_next (addr_next)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dot_reg       <= '0;
            line_reg      <= '0;
            addr_reg      <= '0;
            vblank_reg    <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                dot_reg       <= dot_next;
                line_reg      <= line_next;
                addr_reg      <= addr_next;
                vblank_reg    <= vbl_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            render_reg <= s_tdata[0];
            temp_reg   <= s_tdata[15:1];
        end
        if (advance) begin
            out_dot_reg    <= dot_reg;
            out_line_reg   <= line_reg;
            out_addr_reg   <= addr_next;
            out_vblank_reg <= vbl_next;
            out_nmi_reg    <= nmi;
            out_last_reg   <= frame_end;
        end
    end

    // nametable byte and its attribute byte
    assign nt_addr = {2'b10, out_addr_reg[11:0]};
    assign at_addr = ATTR_BASE | {2'b00, out_addr_reg[11:10], 10'b0}
                   | {8'b0, out_addr_reg[9:7], out_addr_reg[4:2]};

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_nmi_reg, out_vblank_reg, at_addr, nt_addr,
                       out_addr_reg, out_line_reg, out_dot_reg};

endmodule

/* src/vdts_checker.sv */
// ----------------------------------------------------------------------------
// vdts_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_dot_timing_scroll_address_defines.svh"

module vdts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    // stalled result holds
    `VDTS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // NMI only at line 241 dot 1, with vblank set
    `VDTS_ASSERT_NOW(a_nmi, m_tvalid && m_tdata[62], m_tdata[61] && m_tdata[8:0] == 9'd1 && m_tdata[17:9] == 9'd241, "nmi outside vblank start")

    // frame marker only on the last dot of the pre-render line
    `VDTS_ASSERT_NOW(a_last, m_tvalid && m_tlast, m_tdata[8:0] == 9'd340 && m_tdata[17:9] == 9'd261, "tlast off frame end")

    // tile address follows the VRAM address
    `VDTS_ASSERT_NOW(a_tile, m_tvalid, m_tdata[46:33] == {2'b10, m_tdata[29:18]}, "tile address mismatch")

    // input port free whenever an output beat is taken
    `VDTS_ASSERT_NOW(a_ready, m_tvalid && m_tready && s_tvalid, s_tready, "input stalled while output drains")

endmodule

bind video_dot_timing_scroll_address vdts_checker u_vdts_checker (.*);

/* dv/video_dot_timing_scroll_address_tb.sv */
// ----------------------------------------------------------------------------
// video_dot_timing_scroll_address_tb
// Self-checking bench for the dot-rate raster timing and scroll address block.
// One input beat is one video dot. Every accepted dot is run through a local
// raster/address model; the predicted result beat, or the hand-typed one of a
// fixed row, is queued; every output beat is unpacked and compared field by
// field with the oldest entry. A short directed opening is followed by random
// dots in chunks, each chunk with its own idling mode and render-enable
// density. The run covers the first visible lines of a frame: coarse X steps,
// the Y step at dot 256, the horizontal reload at 257 and the prefetch window.
// ----------------------------------------------------------------------------
module video_dot_timing_scroll_address_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import vdts_pkg::*;

    // About 1400 dots in all, split into chunks so every idling mode and the
    // long consumer hold-off get their turn.
    localparam int RANDOM_DOTS  = 1375;
    localparam int CHUNK_DOTS   = 125;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    // Worst case: long sender gaps and receiver stalls on every dot.
    localparam int CYCLE_LIMIT  = 20 * RANDOM_DOTS + 200000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    // One result beat, unpacked.
    typedef struct packed {
        logic [CNT_W-1:0]  dot;
        logic [CNT_W-1:0]  line;
        logic [ADDR_W-1:0] vaddr;
        logic [VADR_W-1:0] tile;
        logic [VADR_W-1:0] attr;
        logic              vblank;
        logic              nmi;
        logic              frame_end;
    } dot_result_t;

    // One row of the directed opening; fixed rows carry a hand-typed result.
    typedef struct {
        logic              render;
        logic [ADDR_W-1:0] temp;
        bit                fixed;
        dot_result_t       want;
    } dot_stim_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [0] render_enable, [15:1] scroll_temp
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [8:0] dot_index, [17:9] line_index, [32:18] vram_address,
    // [46:33] tile_address, [60:47] attribute_address, [61] in_vblank,
    // [62] nmi_pulse, [63] zero
    logic [63:0] m_tdata;
    logic        m_tlast;

    video_dot_timing_scroll_address i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Model raster state, advanced once per accepted dot.
    logic [CNT_W-1:0]  ras_dot;
    logic [CNT_W-1:0]  ras_line;
    logic [ADDR_W-1:0] ras_vaddr;
    logic              ras_vblank;

    dot_result_t pending_dots[$];
    dot_stim_t   opening_dots[25];

    int          err_count;
    int          dots_sent;
    int          dots_checked;
    int          frames_seen;
    int          vblank_pulses;
    int          input_stall_cycles;
    int unsigned cycle_count;

    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_request;

    // ------------------------------------------------------------------
    // Clock and cycle watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycle_count, pending_dots.size());
            $display("video_dot_timing_scroll_address_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Address steps, written per the loopy scroll layout:
    // [4:0] coarse X, [9:5] coarse Y, [11:10] nametable, [14:12] fine Y.
    // ------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] bump_coarse_x(input logic [ADDR_W-1:0] a);
        if (a[4:0] == 5'h1F) begin
            a[4:0] = 5'h00;
            a[10]  = ~a[10];
        end else begin
            a = a + 15'd1;
        end
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] bump_fine_y(input logic [ADDR_W-1:0] a);
        logic [4:0] row;
        if (a[14:12] != 3'd7)
            return a + 15'h1000;
        a[14:12] = 3'd0;
        row = a[9:5];
        if (row == ROW_TOGGLE) begin
            // bottom of the visible nametable: flip the vertical select
            row   = 5'd0;
            a[11] = ~a[11];
        end else if (row == ROW_WRAP) begin
            // rows 30/31 sit in attribute space; row 31 wraps without a flip
            row = 5'd0;
        end else begin
            row = row + 5'd1;
        end
        a[9:5] = row;
        return a;
    endfunction

    // Advance the model by one dot and return the result beat it owes.
    function automatic dot_result_t advance_raster(input logic render,
                                                   input logic [ADDR_W-1:0] temp);
        dot_result_t r;
        logic [ADDR_W-1:0] a;
        r      = '0;
        a      = ras_vaddr;
        r.dot  = ras_dot;
        r.line = ras_line;

        if (ras_line <= LINE_VIS_LAST) begin
            if (render) begin
                if (ras_dot == DOT_Y_STEP)
                    a = bump_fine_y(a);
                else if (ras_dot == DOT_H_COPY)
                    a = (a & ~MASK_HORIZ) | (temp & MASK_HORIZ);
                // tile boundary: dots 8, 16, .. 248; no dot of the prefetch range 337..340 is one
                if (ras_dot != '0 && ras_dot[2:0] == 3'd0 &&
                    (ras_dot < DOT_Y_STEP || ras_dot >= DOT_PREFETCH))
                    a = bump_coarse_x(a);
            end
        end else if (ras_line == LINE_VBLANK) begin
            if (ras_dot == DOT_VBLANK && !ras_vblank) begin
                ras_vblank = 1'b1;
                r.nmi      = 1'b1;
            end
        end else if (ras_line == LINE_LAST) begin
            if (ras_dot == DOT_VBLANK)
                ras_vblank = 1'b0;
            else if (render && ras_dot >= DOT_V_COPY_LO && ras_dot <= DOT_V_COPY_HI)
                a = (a & ~MASK_VERT) | (temp & MASK_VERT);
        end
        ras_vaddr = a;

        if (ras_dot == DOT_LAST) begin
            ras_dot = '0;
            if (ras_line == LINE_LAST) begin
                ras_line    = '0;
                r.frame_end = 1'b1;
            end else begin
                ras_line = ras_line + 9'd1;
            end
        end else begin
            ras_dot = ras_dot + 9'd1;
        end

        r.vaddr  = a;
        r.tile   = {2'b10, a[11:0]};
        r.attr   = ATTR_BASE | {2'b00, a[11:10], 4'b0000, a[9:7], a[4:2]};
        r.vblank = ras_vblank;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: called just after a falling edge, returns just after one.
    // Leaves tvalid high; the caller lowers it when pausing.
    // ------------------------------------------------------------------
    task automatic send_dot(input logic render, input logic [ADDR_W-1:0] temp,
                            input bit fixed, input dot_result_t want);
        dot_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {temp, render};
        do @(posedge aclk); while (!s_tready);
        // beat accepted at this edge
        predicted = advance_raster(render, temp);
        pending_dots.push_back(fixed ? want : predicted);
        dots_sent++;
        @(negedge aclk);
    endtask

    task automatic set_idle_mode(input idle_mode_e mode);
        send_idle_pct  = (mode == IDLE_SENDER)   ? 60 :
                         (mode == IDLE_BOTH)     ? 16 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 60 :
                         (mode == IDLE_BOTH)     ? 16 : 0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request so the
    // block backs up and drops s_tready while beats keep coming.
    // ------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        dot_result_t got;
        dot_result_t want;
        if (aresetn) begin
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
            if (m_tvalid && m_tready) begin
                got.dot       = m_tdata[8:0];
                got.line      = m_tdata[17:9];
                got.vaddr     = m_tdata[32:18];
                got.tile      = m_tdata[46:33];
                got.attr      = m_tdata[60:47];
                got.vblank    = m_tdata[61];
                got.nmi       = m_tdata[62];
                got.frame_end = m_tlast;
                if (pending_dots.size() == 0) begin
                    $display("%0t: unexpected result beat %h (last %b)",
                             $time, m_tdata, m_tlast);
                    err_count++;
                end else begin
                    want = pending_dots.pop_front();
                    flag_field("dot_index",         want.dot,       got.dot);
                    flag_field("line_index",        want.line,      got.line);
                    flag_field("vram_address",      want.vaddr,     got.vaddr);
                    flag_field("tile_address",      want.tile,      got.tile);
                    flag_field("attribute_address", want.attr,      got.attr);
                    flag_field("in_vblank",         want.vblank,    got.vblank);
                    flag_field("nmi_pulse",         want.nmi,       got.nmi);
                    flag_field("frame_end",         want.frame_end, got.frame_end);
                    flag_field("tdata pad bit",     0,              m_tdata[63]);
                    dots_checked++;
                end
                if (got.frame_end)
                    frames_seen++;
                if (got.nmi)
                    vblank_pulses++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic              render;
        logic [ADDR_W-1:0] temp;
        int                render_pct;
        int                chunk;
        int                left;
        int                in_chunk;

        err_count          = 0;
        dots_sent          = 0;
        dots_checked       = 0;
        frames_seen        = 0;
        vblank_pulses      = 0;
        input_stall_cycles = 0;
        cycle_count        = 0;
        hold_request       = 1'b0;
        set_idle_mode(IDLE_NONE);

        ras_dot    = '0;
        ras_line   = '0;
        ras_vaddr  = '0;
        ras_vblank = 1'b0;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        // Opening from reset: dots 0..24 of line 0. Fixed rows are the ones
        // readable by eye: first dot, a disabled dot, and the first two
        // tile-boundary coarse X steps. Dot 24 has rendering off (no step).
        for (int i = 0; i < 25; i++) begin
            opening_dots[i].render = 1'b1;
            opening_dots[i].temp   = 15'(i * 15'h0421);
            opening_dots[i].fixed  = 1'b0;
            opening_dots[i].want   = '0;
        end
        opening_dots[0]  = '{1'b1, 15'h7FFF, 1'b1,
                             '{9'd0,  9'd0, 15'h0000, 14'h2000, 14'h23C0, 1'b0, 1'b0, 1'b0}};
        opening_dots[1]  = '{1'b0, 15'h0000, 1'b1,
                             '{9'd1,  9'd0, 15'h0000, 14'h2000, 14'h23C0, 1'b0, 1'b0, 1'b0}};
        opening_dots[2].temp = 15'h5555;
        opening_dots[3].temp = 15'h2AAA;
        opening_dots[4].temp = MASK_HORIZ;
        opening_dots[5].temp = MASK_VERT;
        opening_dots[6].render = 1'b0;
        opening_dots[8]  = '{1'b1, 15'h0000, 1'b1,
                             '{9'd8,  9'd0, 15'h0001, 14'h2001, 14'h23C0, 1'b0, 1'b0, 1'b0}};
        opening_dots[16] = '{1'b1, 15'h7FFF, 1'b1,
                             '{9'd16, 9'd0, 15'h0002, 14'h2002, 14'h23C0, 1'b0, 1'b0, 1'b0}};
        opening_dots[24].render = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (opening_dots[i])
            send_dot(opening_dots[i].render, opening_dots[i].temp,
                     opening_dots[i].fixed, opening_dots[i].want);

        // Random part. Scroll temp mostly holds for a while, as a program
        // would leave it, with rendering mostly on so the address walks.
        temp  = 15'($urandom_range(0, 32767));
        left  = RANDOM_DOTS;
        chunk = 0;
        while (left > 0) begin
            set_idle_mode(idle_mode_e'(chunk % 4));
            case ($urandom_range(0, 7))
                0:       render_pct = 0;
                1:       render_pct = 60;
                2:       render_pct = 97;
                default: render_pct = 100;
            endcase
            // one long consumer hold-off while the producer keeps pushing
            if (chunk == 4)
                hold_request = 1'b1;
            in_chunk = (left < CHUNK_DOTS) ? left : CHUNK_DOTS;
            for (int i = 0; i < in_chunk; i++) begin
                if ($urandom_range(0, 9) < 2)
                    temp = 15'($urandom_range(0, 32767));
                render = ($urandom_range(0, 99) < render_pct);
                send_dot(render, temp, 1'b0, '0);
            end
            left -= in_chunk;
            chunk++;
            // producer pauses until the block has drained
            s_tvalid <= 1'b0;
            while (pending_dots.size() != 0)
                @(negedge aclk);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Ran %0d dots (%0d checked) over %0d frame wraps, %0d vblank pulses,",
                 dots_sent, dots_checked, frames_seen, vblank_pulses);
        $display("with four idling modes and %0d cycles of input backpressure.",
                 input_stall_cycles);
        if (err_count == 0 && pending_dots.size() == 0) begin
            $display("video_dot_timing_scroll_address_tb: done, clean");
        end else begin
            $display("video_dot_timing_scroll_address_tb: done, errors");
        end
        $finish;
    end

endmodule

/* video_dot_timing_scroll_address.f */
+incdir+src
src/vdts_pkg.sv
src/vdts_timing.sv
src/vdts_scroll.sv
src/video_dot_timing_scroll_address.sv
src/vdts_checker.sv
dv/video_dot_timing_scroll_address_tb.sv
